// ===== rtl/quadrature_knob_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// Quadrature knob decoder assertion macros
// Concurrent check wrappers on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_KNOB_DECODER_DEFINES_SVH
`define QUADRATURE_KNOB_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

`define QKD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qkd: same-cycle check failed");

`define QKD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qkd: next-cycle check failed");

`else

`define QKD_ASSERT_IMP(lbl, ante, cons)

`define QKD_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/qkd_pkg.sv =====
// ----------------------------------------------------------------------------
// Quadrature knob decoder package
// Widths, codes, sequencer types and the Gray transition table.
// ----------------------------------------------------------------------------
package qkd_pkg;

    localparam int POS_W     = 32;
    localparam int SCALE_W   = 8;
    localparam int DEB_W     = 16;
    localparam int PROD_W    = POS_W + SCALE_W;
    localparam int QUO_W     = PROD_W + 1;
    localparam int REM_W     = SCALE_W + 1;
    localparam int CNT_W     = $clog2(PROD_W + 1);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    localparam logic [POS_W-1:0] BOUNCE_REJECT_MS = POS_W'(5);
    localparam logic [DEB_W-1:0] DEBOUNCE_MIN_MS  = DEB_W'(5);

    typedef logic signed [1:0] t_step;

    localparam t_step STEP_NONE = 2'sb00;
    localparam t_step STEP_FWD  = 2'sb01;
    localparam t_step STEP_REV  = 2'sb11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INVERT   = 3'd0,
        CFG_BUTTON   = 3'd1,
        CFG_DEBOUNCE = 3'd2,
        CFG_NUM      = 3'd3,
        CFG_DEN      = 3'd4,
        CFG_LIMITS   = 3'd5,
        CFG_MIN      = 3'd6,
        CFG_MAX      = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_EVAL
    } t_state;

    typedef enum logic [1:0] {
        PH_LIMIT,
        PH_PULL,
        PH_VALUE
    } t_phase;

    function automatic t_step gray_step(input logic [3:0] idx);
        t_step s;
        unique case (idx)
            4'd0:    s = STEP_NONE;
            4'd1:    s = STEP_REV;
            4'd2:    s = STEP_FWD;
            4'd3:    s = STEP_NONE;
            4'd4:    s = STEP_FWD;
            4'd5:    s = STEP_NONE;
            4'd6:    s = STEP_NONE;
            4'd7:    s = STEP_REV;
            4'd8:    s = STEP_REV;
            4'd9:    s = STEP_NONE;
            4'd10:   s = STEP_NONE;
            4'd11:   s = STEP_FWD;
            4'd12:   s = STEP_NONE;
            4'd13:   s = STEP_FWD;
            4'd14:   s = STEP_REV;
            default: s = STEP_NONE;
        endcase
        return s;
    endfunction

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [QUO_W-1:0] v);
        logic signed [QUO_W-1:0] vmax;
        logic signed [QUO_W-1:0] vmin;
        vmax = QUO_W'({1'b0, {(POS_W-1){1'b1}}});
        vmin = -vmax - QUO_W'(1);
        if (v > vmax) begin
            return {1'b0, {(POS_W-1){1'b1}}};
        end else if (v < vmin) begin
            return {1'b1, {(POS_W-1){1'b0}}};
        end
        return v[POS_W-1:0];
    endfunction

endpackage

// ===== rtl/qkd_if.sv =====
// ----------------------------------------------------------------------------
// Quadrature knob decoder channels
// Valid/ready sample channel and result channel.
// ----------------------------------------------------------------------------
interface qkd_in_if;
    import qkd_pkg::*;

    logic             valid;
    logic             ready;
    logic             a_first;
    logic             b_first;
    logic             a_second;
    logic             b_second;
    logic             switch_level;
    logic [POS_W-1:0] now_ms;

    modport source (
        output valid, a_first, b_first, a_second, b_second, switch_level, now_ms,
        input  ready
    );

    modport sink (
        input  valid, a_first, b_first, a_second, b_second, switch_level, now_ms,
        output ready
    );
endinterface

interface qkd_out_if;
    import qkd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [1:0]       step;
    logic signed [POS_W-1:0] scaled_value;
    logic                    frame_unstable;
    logic                    button_down;
    logic                    press_pulse;
    logic                    release_pulse;

    modport source (
        output valid, step, scaled_value, frame_unstable, button_down, press_pulse,
               release_pulse,
        input  ready
    );

    modport sink (
        input  valid, step, scaled_value, frame_unstable, button_down, press_pulse,
               release_pulse,
        output ready
    );
endinterface

// ===== rtl/quadrature_knob_decoder.sv =====
// Each accepted word passes through a 40-step bit-serial divider, which runs once per word and
// three times when the position is pulled back; no new word is taken until its result is registered.
// A new word is taken while the previous result word still waits at the output.
// Reset (synchronous, active low) restores control, position, decoder and config registers to defaults;
// the serial datapath and result/output payload registers are not reset.
// ----------------------------------------------------------------------------
// Quadrature knob decoder
// Gray step decoding with bounce reject, wrapping position, serial scaling,
// limit pull-back and clamping, and push-button debounce.
// ----------------------------------------------------------------------------
`include "quadrature_knob_decoder_defines.svh"

module quadrature_knob_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    qkd_in_if.sink                         i_in,
    qkd_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [qkd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [qkd_pkg::CFG_W-1:0]      i_cfg_data
);
    import qkd_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    logic                    r_cfg_invert;
    logic                    r_cfg_button;
    logic [DEB_W-1:0]        r_cfg_debounce;
    logic [SCALE_W-1:0]      r_cfg_num;
    logic [SCALE_W-1:0]      r_cfg_den;
    logic                    r_cfg_limits;
    logic signed [POS_W-1:0] r_cfg_min;
    logic signed [POS_W-1:0] r_cfg_max;

    logic signed [POS_W-1:0] r_pos, n_pos;
    logic [1:0]              r_prev_ab, n_prev_ab;
    t_step                   r_last_dir, n_last_dir;
    logic [POS_W-1:0]        r_last_time, n_last_time;
    logic                    r_sw_prev, n_sw_prev;
    logic                    r_sw_stable, n_sw_stable;
    logic [POS_W-1:0]        r_sw_time, n_sw_time;

    logic signed [POS_W-1:0] r_op, n_op;
    logic [SCALE_W-1:0]      r_mult, n_mult;
    logic [SCALE_W-1:0]      r_divisor, n_divisor;
    logic                    r_neg, n_neg;
    logic [PROD_W-1:0]       r_dvd, n_dvd;
    logic [REM_W-1:0]        r_rem, n_rem;
    logic [CNT_W-1:0]        r_cnt, n_cnt;

    t_step                   r_res_step, n_res_step;
    logic                    r_res_unstable, n_res_unstable;
    logic                    r_res_down, n_res_down;
    logic                    r_res_press, n_res_press;
    logic                    r_res_release, n_res_release;

    logic                    r_out_valid, n_out_valid;
    t_step                   r_out_step, n_out_step;
    logic signed [POS_W-1:0] r_out_value, n_out_value;
    logic                    r_out_unstable, n_out_unstable;
    logic                    r_out_down, n_out_down;
    logic                    r_out_press, n_out_press;
    logic                    r_out_release, n_out_release;

    logic [SCALE_W-1:0]      w_num;
    logic [SCALE_W-1:0]      w_den;
    logic [DEB_W-1:0]        w_debounce;
    logic signed [POS_W-1:0] w_lo;
    logic signed [POS_W-1:0] w_hi;

    logic                    w_accept;
    logic                    w_unstable;
    logic [1:0]              w_cur_ab;
    t_step                   w_raw_d;
    t_step                   w_d;
    logic                    w_back;
    logic                    w_take;
    logic                    w_pressed;
    logic [POS_W-1:0]        w_chg_time;
    logic                    w_flip;

    logic [POS_W-1:0]        w_mag;
    logic [REM_W-1:0]        w_rem_sh;
    logic                    w_ge;
    logic signed [QUO_W-1:0] w_q;
    logic signed [QUO_W-1:0] w_lo_x;
    logic signed [QUO_W-1:0] w_hi_x;
    logic                    w_gt_hi;
    logic                    w_lt_lo;
    logic signed [POS_W-1:0] w_final;
    logic                    w_out_free;
    logic                    w_last_pass;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_invert   <= 1'b0;
            r_cfg_button   <= 1'b1;
            r_cfg_debounce <= DEB_W'(30);
            r_cfg_num      <= SCALE_W'(1);
            r_cfg_den      <= SCALE_W'(1);
            r_cfg_limits   <= 1'b0;
            r_cfg_min      <= '0;
            r_cfg_max      <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_INVERT:   r_cfg_invert   <= i_cfg_data[0];
                CFG_BUTTON:   r_cfg_button   <= i_cfg_data[0];
                CFG_DEBOUNCE: r_cfg_debounce <= i_cfg_data[DEB_W-1:0];
                CFG_NUM:      r_cfg_num      <= i_cfg_data[SCALE_W-1:0];
                CFG_DEN:      r_cfg_den      <= i_cfg_data[SCALE_W-1:0];
                CFG_LIMITS:   r_cfg_limits   <= i_cfg_data[0];
                CFG_MIN:      r_cfg_min      <= i_cfg_data[POS_W-1:0];
                CFG_MAX:      r_cfg_max      <= i_cfg_data[POS_W-1:0];
                default:      r_cfg_limits   <= r_cfg_limits;
            endcase
        end
    end

    always_comb begin
        w_num      = (r_cfg_num == '0) ? SCALE_W'(1) : r_cfg_num;
        w_den      = (r_cfg_den == '0) ? SCALE_W'(1) : r_cfg_den;
        w_debounce = (r_cfg_debounce < DEBOUNCE_MIN_MS) ? DEBOUNCE_MIN_MS : r_cfg_debounce;
        w_lo       = (r_cfg_min > r_cfg_max) ? r_cfg_max : r_cfg_min;
        w_hi       = (r_cfg_min > r_cfg_max) ? r_cfg_min : r_cfg_max;
    end

    // ---------------------------------------------------------- sample decode
    always_comb begin
        w_accept   = i_in.valid && i_in.ready;
        w_unstable = (i_in.a_first != i_in.a_second) || (i_in.b_first != i_in.b_second);
        w_cur_ab   = {i_in.a_first, i_in.b_first};
        w_raw_d    = gray_step({r_prev_ab, w_cur_ab});
        w_d        = r_cfg_invert ? -w_raw_d : w_raw_d;
        w_back     = (r_last_dir != STEP_NONE) && (w_d == -r_last_dir)
                     && ((i_in.now_ms - r_last_time) < BOUNCE_REJECT_MS);
        w_take     = !w_unstable && (w_d != STEP_NONE) && !w_back;
        w_pressed  = !i_in.switch_level;
        w_chg_time = (w_pressed != r_sw_prev) ? i_in.now_ms : r_sw_time;
        w_flip     = ((i_in.now_ms - w_chg_time) >= POS_W'(w_debounce))
                     && (w_pressed != r_sw_stable);
    end

    // -------------------------------------------------------- serial datapath
    always_comb begin
        w_mag       = r_op[POS_W-1] ? POS_W'(-r_op) : POS_W'(r_op);
        w_rem_sh    = {r_rem[REM_W-2:0], r_dvd[PROD_W-1]};
        w_ge        = w_rem_sh >= REM_W'(r_divisor);
        w_q         = r_neg ? -QUO_W'({1'b0, r_dvd}) : QUO_W'({1'b0, r_dvd});
        w_lo_x      = QUO_W'(w_lo);
        w_hi_x      = QUO_W'(w_hi);
        w_gt_hi     = w_q > w_hi_x;
        w_lt_lo     = w_q < w_lo_x;
        w_out_free  = !r_out_valid || o_out.ready;
        w_last_pass = (r_phase == PH_VALUE) || ((r_phase == PH_LIMIT) && !w_gt_hi && !w_lt_lo);
        if (r_cfg_limits && w_lt_lo) begin
            w_final = w_lo;
        end else if (r_cfg_limits && w_gt_hi) begin
            w_final = w_hi;
        end else begin
            w_final = sat32(w_q);
        end
    end

    // ------------------------------------------------------------ next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!w_last_pass) begin
                    n_state = S_MUL;
                end else if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // -------------------------------------------------------- datapath update
    always_comb begin
        n_phase        = r_phase;
        n_pos          = r_pos;
        n_prev_ab      = r_prev_ab;
        n_last_dir     = r_last_dir;
        n_last_time    = r_last_time;
        n_sw_prev      = r_sw_prev;
        n_sw_stable    = r_sw_stable;
        n_sw_time      = r_sw_time;
        n_op           = r_op;
        n_mult         = r_mult;
        n_divisor      = r_divisor;
        n_neg          = r_neg;
        n_dvd          = r_dvd;
        n_rem          = r_rem;
        n_cnt          = r_cnt;
        n_res_step     = r_res_step;
        n_res_unstable = r_res_unstable;
        n_res_down     = r_res_down;
        n_res_press    = r_res_press;
        n_res_release  = r_res_release;
        n_out_valid    = r_out_valid && !o_out.ready;
        n_out_step     = r_out_step;
        n_out_value    = r_out_value;
        n_out_unstable = r_out_unstable;
        n_out_down     = r_out_down;
        n_out_press    = r_out_press;
        n_out_release  = r_out_release;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res_unstable = w_unstable;
                    n_res_step     = w_take ? w_d : STEP_NONE;
                    n_op           = r_pos;
                    if (!w_unstable) begin
                        n_prev_ab = w_cur_ab;
                    end
                    if (w_take) begin
                        n_pos       = r_pos + POS_W'(w_d);
                        n_op        = r_pos + POS_W'(w_d);
                        n_last_dir  = w_d;
                        n_last_time = i_in.now_ms;
                    end
                    n_res_down    = 1'b0;
                    n_res_press   = 1'b0;
                    n_res_release = 1'b0;
                    if (r_cfg_button) begin
                        n_sw_time  = w_chg_time;
                        n_sw_prev  = w_pressed;
                        n_res_down = r_sw_stable;
                        if (w_flip) begin
                            n_sw_stable   = w_pressed;
                            n_res_down    = w_pressed;
                            n_res_press   = w_pressed;
                            n_res_release = !w_pressed;
                        end
                    end
                    n_mult    = w_num;
                    n_divisor = w_den;
                    n_phase   = r_cfg_limits ? PH_LIMIT : PH_VALUE;
                end
            end
            S_MUL: begin
                n_neg = r_op[POS_W-1];
                n_dvd = PROD_W'(w_mag) * PROD_W'(r_mult);
                n_rem = '0;
                n_cnt = CNT_W'(PROD_W);
            end
            S_DIV: begin
                n_rem = w_ge ? (w_rem_sh - REM_W'(r_divisor)) : w_rem_sh;
                n_dvd = {r_dvd[PROD_W-2:0], w_ge};
                n_cnt = r_cnt - CNT_W'(1);
            end
            S_EVAL: begin
                if (r_phase == PH_LIMIT && (w_gt_hi || w_lt_lo)) begin
                    n_op      = w_gt_hi ? w_hi : w_lo;
                    n_mult    = w_den;
                    n_divisor = w_num;
                    n_phase   = PH_PULL;
                end else if (r_phase == PH_PULL) begin
                    n_pos     = sat32(w_q);
                    n_op      = sat32(w_q);
                    n_mult    = w_num;
                    n_divisor = w_den;
                    n_phase   = PH_VALUE;
                end else if (w_out_free) begin
                    n_out_valid    = 1'b1;
                    n_out_step     = r_res_step;
                    n_out_value    = w_final;
                    n_out_unstable = r_res_unstable;
                    n_out_down     = r_res_down;
                    n_out_press    = r_res_press;
                    n_out_release  = r_res_release;
                end
            end
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_VALUE;
            r_pos       <= '0;
            r_prev_ab   <= '0;
            r_last_dir  <= STEP_NONE;
            r_last_time <= '0;
            r_sw_prev   <= 1'b0;
            r_sw_stable <= 1'b0;
            r_sw_time   <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_prev_ab   <= n_prev_ab;
            r_last_dir  <= n_last_dir;
            r_last_time <= n_last_time;
            r_sw_prev   <= n_sw_prev;
            r_sw_stable <= n_sw_stable;
            r_sw_time   <= n_sw_time;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op           <= n_op;
        r_mult         <= n_mult;
        r_divisor      <= n_divisor;
        r_neg          <= n_neg;
        r_dvd          <= n_dvd;
        r_rem          <= n_rem;
        r_res_step     <= n_res_step;
        r_res_unstable <= n_res_unstable;
        r_res_down     <= n_res_down;
        r_res_press    <= n_res_press;
        r_res_release  <= n_res_release;
        r_out_step     <= n_out_step;
        r_out_value    <= n_out_value;
        r_out_unstable <= n_out_unstable;
        r_out_down     <= n_out_down;
        r_out_press    <= n_out_press;
        r_out_release  <= n_out_release;
    end

    // --------------------------------------------------------------- outputs
    always_comb begin
        i_in.ready           = (r_state == S_IDLE);
        o_out.valid          = r_out_valid;
        o_out.step           = r_out_step;
        o_out.scaled_value   = r_out_value;
        o_out.frame_unstable = r_out_unstable;
        o_out.button_down    = r_out_down;
        o_out.press_pulse    = r_out_press;
        o_out.release_pulse  = r_out_release;
    end

    // ------------------------------------------------------------ assertions
    `QKD_ASSERT_NXT(a_accept_starts_mul, i_in.valid && i_in.ready, r_state == S_MUL)
    `QKD_ASSERT_IMP(a_unstable_no_step, r_out_valid && r_out_unstable, r_out_step == STEP_NONE)
    `QKD_ASSERT_IMP(a_press_sets_down, r_out_valid && r_out_press, r_out_down && !r_out_release)
    `QKD_ASSERT_NXT(a_div_count_down, r_state == S_DIV && r_cnt != CNT_W'(1), r_state == S_DIV)

endmodule
